>>> src/swrl_pkg.sv
package swrl_pkg;

    // fixed field widths
    localparam int TIME_BITS  = 48;
    localparam int KEY_BITS   = 6;
    localparam int CNT_BITS   = 31;
    localparam int WAIT_BITS  = 32;
    localparam int MWE_BITS   = 5;
    localparam int SCOPE_BITS = 2;

    // defaults for the top-level parameters
    localparam int DEF_NUM_KEYS   = 64;
    localparam int DEF_MAX_EVENTS = 16;

    // session count saturation point
    localparam logic [CNT_BITS-1:0] CNT_SATURATE = 31'h7fff_ffff;

    // request codes
    localparam logic REQ_EVAL   = 1'b0;
    localparam logic REQ_RECORD = 1'b1;

    // cap scope codes
    localparam logic [SCOPE_BITS-1:0] CAP_NONE    = 2'd0;
    localparam logic [SCOPE_BITS-1:0] CAP_SESSION = 2'd1;
    localparam logic [SCOPE_BITS-1:0] CAP_WINDOW  = 2'd2;

    // register indexes
    localparam int PADDR_BITS = 4;
    localparam logic [1:0] REG_MAX_SESSION = 2'd0;
    localparam logic [1:0] REG_MAX_WINDOW  = 2'd1;
    localparam logic [1:0] REG_WINDOW_TICK = 2'd2;

    typedef struct packed {
        logic [CNT_BITS-1:0]  max_session_impressions;
        logic [MWE_BITS-1:0]  max_window_events;
        logic [WAIT_BITS-1:0] window_ticks;
    } t_cfg;

    // classified request handed from front to back
    typedef struct packed {
        logic                 req_type;
        logic [KEY_BITS-1:0]  key_index;
        logic [TIME_BITS-1:0] now_ticks;
        logic                 in_range;
    } t_item;

endpackage

>>> src/swrl_if.sv
interface swrl_req_if;
    import swrl_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [KEY_BITS-1:0]  key_index;
    logic [TIME_BITS-1:0] now_ticks;
    modport source (output valid, req_type, key_index, now_ticks, input ready);
    modport sink (input valid, req_type, key_index, now_ticks, output ready);
endinterface

interface swrl_rsp_if;
    import swrl_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [SCOPE_BITS-1:0] cap_scope;
    logic [WAIT_BITS-1:0]  wait_ticks;
    logic                  recorded;
    modport source (output valid, cap_scope, wait_ticks, recorded, input ready);
    modport sink (input valid, cap_scope, wait_ticks, recorded, output ready);
endinterface

>>> src/sliding_window_rate_limiter.sv
// sliding window rate limiter
// i_req carries transactions (req_type, key_index, now_ticks); req_type 0
// evaluates the caps of a key, 1 records an event for it. o_rsp returns one
// transaction per request (cap_scope, wait_ticks, recorded) in request order.
// both channels use valid/ready; a transaction moves when both are high.
// the APB port sets max_session_impressions (0x0), max_window_events (0x4)
// and window_ticks (0x8); write it only while no request is outstanding.
// a two-entry queue takes requests while the back end works or its result
// waits on a stalled receiver; a stalled o_rsp holds its transaction.
// a key out of range goes straight to o_rsp; an evaluate reads the key's
// count and ring pointers and, when the window cap may bind, one stored
// event time; a record with window limiting off writes back its count;
// a windowed record, once now_ticks reaches window_ticks, scans the ring
// one stored time at a time and drops expired ones, then appends and trims.
// one request is worked at a time; the next is taken once o_rsp accepts.
// reset clears configuration, all per-key counts and rings at once (valid
// bit per key); event times are written before they are ever used.
module sliding_window_rate_limiter #(
    parameter int NUM_KEYS   = swrl_pkg::DEF_NUM_KEYS,
    parameter int MAX_EVENTS = swrl_pkg::DEF_MAX_EVENTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    swrl_req_if.sink                        i_req,
    swrl_rsp_if.source                      o_rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swrl_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import swrl_pkg::*;

    t_cfg  r_cfg;
    t_item w_item;
    logic  w_item_valid;
    logic  w_item_pop;
    logic  w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_MAX_SESSION: r_cfg.max_session_impressions <= pwdata[CNT_BITS-1:0];
                REG_MAX_WINDOW:  r_cfg.max_window_events <= pwdata[MWE_BITS-1:0];
                REG_WINDOW_TICK: r_cfg.window_ticks <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[3:2])
            REG_MAX_SESSION: prdata = 32'(r_cfg.max_session_impressions);
            REG_MAX_WINDOW:  prdata = 32'(r_cfg.max_window_events);
            REG_WINDOW_TICK: prdata = r_cfg.window_ticks;
            default:         prdata = '0;
        endcase
    end

    swrl_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_pop   (w_item_pop)
    );

    swrl_back #(
        .NUM_KEYS   (NUM_KEYS),
        .MAX_EVENTS (MAX_EVENTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .o_rsp        (o_rsp)
    );

endmodule

>>> src/swrl_front.sv
module swrl_front #(
    parameter int NUM_KEYS = swrl_pkg::DEF_NUM_KEYS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    swrl_req_if.sink          i_req,
    output logic              o_item_valid,
    output swrl_pkg::t_item   o_item,
    input  logic              i_item_pop
);
    import swrl_pkg::*;

    logic [1:0] r_cnt;
    logic       r_wp;
    logic       r_rp;
    t_item      r_q [2];
    t_item      w_in;
    logic       w_push;
    logic       w_pop;

    // classify: flag keys beyond the table
    always_comb begin
        w_in.req_type  = i_req.req_type;
        w_in.key_index = i_req.key_index;
        w_in.now_ticks = i_req.now_ticks;
        w_in.in_range  = (32'(i_req.key_index) < NUM_KEYS);
    end

    assign i_req.ready  = (r_cnt != 2'd2);
    assign w_push       = i_req.valid && i_req.ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];
    assign w_pop        = i_item_pop && o_item_valid;

    // two-entry queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !w_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |=> r_cnt != 2'd3) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");

endmodule

>>> src/swrl_back.sv
module swrl_back #(
    parameter int NUM_KEYS   = swrl_pkg::DEF_NUM_KEYS,
    parameter int MAX_EVENTS = swrl_pkg::DEF_MAX_EVENTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swrl_pkg::t_cfg    i_cfg,
    input  logic              i_item_valid,
    input  swrl_pkg::t_item   i_item,
    output logic              o_item_pop,
    swrl_rsp_if.source        o_rsp
);
    import swrl_pkg::*;

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int EW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int FW = $clog2(MAX_EVENTS + 1);
    localparam int NE = NUM_KEYS * MAX_EVENTS;
    localparam int AW = (NE > 1) ? $clog2(NE) : 1;
    localparam int MW = CNT_BITS + EW + FW;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_META     = 4'd1;
    localparam logic [3:0] S_EVAL_RD  = 4'd2;
    localparam logic [3:0] S_EVAL_FIN = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_SCAN_CHK = 4'd5;
    localparam logic [3:0] S_APPEND   = 4'd6;
    localparam logic [3:0] S_TRIM     = 4'd7;
    localparam logic [3:0] S_WB       = 4'd8;
    localparam logic [3:0] S_OUT      = 4'd9;

    // ring slot wrap, operands below twice the ring size
    function automatic logic [EW-1:0] wrap(input logic [EW:0] s);
        logic [EW:0] r;
        r = (32'(s) >= MAX_EVENTS) ? s - (EW+1)'(MAX_EVENTS) : s;
        return r[EW-1:0];
    endfunction

    logic [3:0]            r_state;
    t_item                 r_item;
    logic [MW-1:0]         r_meta_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0]   r_meta_vld;
    logic [MW-1:0]         r_meta_q;
    logic                  r_meta_vq;
    logic [TIME_BITS-1:0]  r_evt_mem [NE];
    logic [TIME_BITS-1:0]  r_evt_q;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [EW-1:0]         r_head;
    logic [FW-1:0]         r_fill;
    logic [TIME_BITS-1:0]  r_oldest;
    logic                  r_ge;
    logic [TIME_BITS-1:0]  r_diff;
    logic [SCOPE_BITS-1:0] r_scope;
    logic [WAIT_BITS-1:0]  r_wait;
    logic                  r_recorded;

    logic [CNT_BITS-1:0]   w_m_cnt;
    logic [EW-1:0]         w_m_head;
    logic [FW-1:0]         w_m_fill;
    logic                  w_win;
    logic [7:0]            w_cap;
    logic [7:0]            w_cap_eff;
    logic [KW-1:0]         w_key;
    logic [AW-1:0]         w_key_base;
    logic                  w_evt_rd;
    logic [EW-1:0]         w_evt_slot;
    logic                  w_evt_wr;
    logic [EW-1:0]         w_h1;
    logic [FW-1:0]         w_f1;
    logic [WAIT_BITS:0]    w_sum;

    assign w_key      = KW'(r_item.key_index);
    assign w_key_base = AW'(w_key) * AW'(MAX_EVENTS);
    assign w_win      = (i_cfg.max_window_events != '0) && (i_cfg.window_ticks != '0);
    assign w_cap      = 8'(i_cfg.max_window_events);
    assign w_cap_eff  = (32'(w_cap) > MAX_EVENTS) ? 8'(MAX_EVENTS) : w_cap;
    assign {w_m_cnt, w_m_head, w_m_fill} = r_meta_vq ? r_meta_q : '0;

    // append: make room when the ring is full
    always_comb begin
        if (32'(r_fill) >= MAX_EVENTS) begin
            w_h1 = wrap({1'b0, r_head} + (EW+1)'(1));
            w_f1 = r_fill - FW'(1);
        end else begin
            w_h1 = r_head;
            w_f1 = r_fill;
        end
    end

    // event memory access selection
    always_comb begin
        w_evt_rd   = 1'b0;
        w_evt_wr   = 1'b0;
        w_evt_slot = r_head;
        unique case (r_state)
            S_META: begin
                w_evt_rd   = 1'b1;
                w_evt_slot = wrap({1'b0, w_m_head} +
                                  (EW+1)'(8'(w_m_fill) - w_cap));
            end
            S_SCAN_RD: begin
                w_evt_rd = 1'b1;
            end
            S_APPEND: begin
                w_evt_wr   = 1'b1;
                w_evt_slot = wrap({1'b0, w_h1} + (EW+1)'(w_f1));
            end
            default: begin
                w_evt_rd = 1'b0;
            end
        endcase
    end

    // event time memory
    always_ff @(posedge i_clk) begin
        if (w_evt_wr) begin
            r_evt_mem[w_key_base + AW'(w_evt_slot)] <= r_item.now_ticks;
        end
        if (w_evt_rd) begin
            r_evt_q <= r_evt_mem[w_key_base + AW'(w_evt_slot)];
        end
    end

    // per-key count and ring pointers, read when an item is taken
    always_ff @(posedge i_clk) begin
        if (r_state == S_WB) begin
            r_meta_mem[w_key] <= {r_cnt, r_head, r_fill};
        end
        if (r_state == S_IDLE) begin
            r_meta_q <= r_meta_mem[KW'(i_item.key_index)];
        end
    end

    assign w_sum      = (WAIT_BITS+1)'(r_diff[WAIT_BITS-1:0]) +
                        (WAIT_BITS+1)'(i_cfg.window_ticks);
    assign o_item_pop = (r_state == S_IDLE);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_meta_vld <= '0;
            r_meta_vq  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_item     <= i_item;
                        r_meta_vq  <= r_meta_vld[KW'(i_item.key_index)];
                        r_scope    <= CAP_NONE;
                        r_wait     <= '0;
                        r_recorded <= 1'b0;
                        r_state    <= i_item.in_range ? S_META : S_OUT;
                    end
                end
                S_META: begin
                    r_head <= w_m_head;
                    r_fill <= w_m_fill;
                    if (r_item.req_type == REQ_EVAL) begin
                        if (i_cfg.max_session_impressions != '0 &&
                            w_m_cnt >= i_cfg.max_session_impressions) begin
                            r_scope <= CAP_SESSION;
                            r_state <= S_OUT;
                        end else if (!w_win || 8'(w_m_fill) < w_cap) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_EVAL_RD;
                        end
                    end else begin
                        r_cnt <= (w_m_cnt < CNT_SATURATE) ? w_m_cnt + CNT_BITS'(1) : w_m_cnt;
                        r_oldest <= r_item.now_ticks - TIME_BITS'(i_cfg.window_ticks);
                        if (!w_win) begin
                            r_state <= S_WB;
                        end else if (r_item.now_ticks >= TIME_BITS'(i_cfg.window_ticks)) begin
                            r_state <= S_SCAN_RD;
                        end else begin
                            r_state <= S_APPEND;
                        end
                    end
                end
                S_EVAL_RD: begin
                    r_ge    <= (r_item.now_ticks >= r_evt_q);
                    r_diff  <= (r_item.now_ticks >= r_evt_q) ?
                               r_item.now_ticks - r_evt_q : r_evt_q - r_item.now_ticks;
                    r_state <= S_EVAL_FIN;
                end
                S_EVAL_FIN: begin
                    if (r_ge) begin
                        if (r_diff < TIME_BITS'(i_cfg.window_ticks)) begin
                            r_scope <= CAP_WINDOW;
                            r_wait  <= i_cfg.window_ticks - r_diff[WAIT_BITS-1:0];
                        end
                    end else begin
                        r_scope <= CAP_WINDOW;
                        if (r_diff >= TIME_BITS'(32'hffff_ffff) || w_sum[WAIT_BITS]) begin
                            r_wait <= '1;
                        end else begin
                            r_wait <= w_sum[WAIT_BITS-1:0];
                        end
                    end
                    r_state <= S_OUT;
                end
                S_SCAN_RD: begin
                    r_state <= (r_fill == '0) ? S_APPEND : S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (r_evt_q <= r_oldest) begin
                        r_head  <= wrap({1'b0, r_head} + (EW+1)'(1));
                        r_fill  <= r_fill - FW'(1);
                        r_state <= S_SCAN_RD;
                    end else begin
                        r_state <= S_APPEND;
                    end
                end
                S_APPEND: begin
                    r_head  <= w_h1;
                    r_fill  <= w_f1 + FW'(1);
                    r_state <= S_TRIM;
                end
                S_TRIM: begin
                    if (8'(r_fill) > w_cap_eff) begin
                        r_head <= wrap({1'b0, r_head} + (EW+1)'(1));
                        r_fill <= r_fill - FW'(1);
                    end else begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_meta_vld[w_key] <= 1'b1;
                    r_recorded        <= 1'b1;
                    r_state           <= S_OUT;
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid      = (r_state == S_OUT);
    assign o_rsp.cap_scope  = r_scope;
    assign o_rsp.wait_ticks = r_wait;
    assign o_rsp.recorded   = r_recorded;

    a_rec_uncapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.recorded |-> o_rsp.cap_scope == CAP_NONE)
        else $error("record transaction reported a cap");
    a_win_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.cap_scope == CAP_WINDOW |-> o_rsp.wait_ticks != '0)
        else $error("window cap without wait");
    a_nowin_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.cap_scope != CAP_WINDOW |-> o_rsp.wait_ticks == '0)
        else $error("wait without window cap");
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WB |-> 32'(r_fill) <= MAX_EVENTS)
        else $error("ring fill beyond ring size");

endmodule
